// ===== hw/rtl/bpcc_pkg.sv =====
package bpcc_pkg;

    // CORDIC depth, one register stage per step
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    // Datapath widths: vector components carry 16 fraction bits plus gain growth
    localparam int VEC_W = 35;
    localparam int ANG_W = 33;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // Stage map: six prep stages, the CORDIC steps, two finishing stages
    localparam int ST_P0      = 0;
    localparam int ST_P1      = 1;
    localparam int ST_P2      = 2;
    localparam int ST_P3      = 3;
    localparam int ST_P4      = 4;
    localparam int ST_P5      = 5;
    localparam int ST_C0      = 6;
    localparam int ST_E1      = ST_C0 + CORDIC_STEPS;
    localparam int ST_E2      = ST_E1 + 1;
    localparam int NUM_STAGES = ST_E2 + 1;

    // atan(2^-i), full circle = 2^32
    localparam logic [31:0] ATAN_BIN [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [14:0] TURN_64THS   = 15'd23040;
    localparam logic [14:0] BEARING_90   = 15'd5760;
    localparam logic [15:0] MAG_LIMIT    = 16'd46341;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [31:0] QUARTER_BIN  = 32'h4000_0000;

    localparam logic signed [ANG_W-1:0] Z_QUARTER = 33'sh0_4000_0000;
    localparam logic signed [ANG_W-1:0] Z_HALF    = 33'sh0_8000_0000;

    // bearing (1/64 deg) to binary angle: 2^32/23040 = 2^23/45
    // floor(2^20/45), used to split the bearing into a/45 and a%45
    localparam logic [14:0] RECIP_45      = 15'd23301;
    // 2^23 = 45*186413 + 23
    localparam logic [17:0] FRAC_STEP     = 18'd186413;
    localparam logic [10:0] FRAC_STEP_REM = 11'd23;
    localparam logic [10:0] FRAC_ROUND    = 11'd22;
    // ceil(2^16/45), exact for the small remainders used here
    localparam logic [10:0] RECIP_45_FINE = 11'd1457;

    localparam logic signed [18:0] COMP_MAX = 19'sd46341;

    typedef enum logic {
        REQ_TO_POLAR = 1'b0,
        REQ_TO_RECT  = 1'b1
    } t_req;

    // fields that ride along with every transaction
    typedef struct packed {
        t_req               mode;
        logic [14:0]        ang;
        logic [15:0]        mag;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } t_meta;

    // bearing conversion scratch for the rectangular path
    typedef struct packed {
        logic [8:0]  q;
        logic [6:0]  r;
        logic [22:0] lo;
        logic [31:0] x0;
    } t_prep;

endpackage

// ===== hw/rtl/bearing_polar_cartesian_convert.sv =====
// Compass-bearing polar/rectangular converter.
// Input channel (s_axis): tuser selects the request, 0 = rectangular to polar
// (x, y -> bearing, magnitude), 1 = polar to rectangular (bearing, magnitude -> x, y).
// Output channel (m_axis): every transaction carries bearing, magnitude, x and y;
// the input pair of the request is echoed (bearing reduced mod 360 deg and
// magnitude saturated in polar-to-rectangular mode).
// Angles are in 1/64 degree, bearings measured clockwise from +y.
// Pipeline from input transaction to result on m_axis: six prep stages
// (bearing to binary angle, gain scaling, quadrant fold), one register per CORDIC
// step, and two output stages (rescale multiply, then round/saturate into the
// output register).
// Throughput: one transaction per cycle while m_axis_tready does not stall a full
// pipeline; the CORDIC steps are unrolled with no state shared between transactions.
// Stalls: each stage holds its valid bit and advances when the stage after it
// is empty or moving, so bubbles are squeezed out and input is still accepted
// while a result waits on m_axis_tready, until every stage holds data.
// Reset (i_rst_n low, synchronous) empties the pipeline; data registers keep
// whatever they hold.
module bearing_polar_cartesian_convert
    import bpcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] in_x, [31:16] in_y, [46:32] in_angle, [62:47] in_mag, [63] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [14:0] out_angle, [30:15] out_mag, [47:31] out_x, [64:48] out_y, [71:65] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[ST_E2];

    // ------------------------------------------------------------------
    // Stage P0: unpack, reduce bearing mod 360 deg, saturate magnitude
    // ------------------------------------------------------------------
    t_meta r_meta [ST_E2];
    t_meta n_meta0;

    always_comb begin
        logic [14:0] in_angle;
        logic [15:0] in_mag;
        in_angle      = s_axis_tdata[46:32];
        in_mag        = s_axis_tdata[62:47];
        n_meta0.mode  = t_req'(s_axis_tuser);
        n_meta0.ex    = s_axis_tdata[15:0];
        n_meta0.ey    = s_axis_tdata[31:16];
        // 15-bit input never reaches two turns, one subtract suffices
        n_meta0.ang   = (in_angle >= TURN_64THS) ? in_angle - TURN_64THS : in_angle;
        n_meta0.mag   = (in_mag > MAG_LIMIT) ? MAG_LIMIT : in_mag;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_meta[0] <= n_meta0;
        end
        for (int k = 1; k < ST_E2; k++) begin
            if (en[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages P1..P4: binary bearing = round(a * 2^32 / 23040)
    //   a = 45q + r  ->  B = q * 2^23 + 186413 r + floor((23 r + 22) / 45)
    // ------------------------------------------------------------------
    t_prep r_prep [ST_P1:ST_P4];
    t_prep n_prep1, n_prep2, n_prep3, n_prep4;

    // P1: quotient estimate (low by at most one), start magnitude with gain removed
    always_comb begin
        logic [29:0] q_prod;
        logic [45:0] g_prod;
        q_prod     = 30'(r_meta[ST_P0].ang) * 30'(RECIP_45);
        g_prod     = 46'(r_meta[ST_P0].mag) * 46'(INV_GAIN_Q30);
        n_prep1    = '0;
        n_prep1.q  = q_prod[28:20];
        n_prep1.x0 = 32'((g_prod + 46'd8192) >> 14);
    end

    // P2: remainder estimate, 0..89
    always_comb begin
        logic [15:0] rem;
        rem       = 16'(r_meta[ST_P1].ang) - 16'(r_prep[ST_P1].q) * 16'd45;
        n_prep2   = r_prep[ST_P1];
        n_prep2.r = rem[6:0];
    end

    // P3: one correction step
    always_comb begin
        n_prep3 = r_prep[ST_P2];
        if (r_prep[ST_P2].r >= 7'd45) begin
            n_prep3.q = r_prep[ST_P2].q + 9'd1;
            n_prep3.r = r_prep[ST_P2].r - 7'd45;
        end
    end

    // P4: low 23 bits of the binary bearing
    always_comb begin
        logic [22:0] coarse;
        logic [10:0] dnum;
        logic [20:0] fine;
        coarse     = 23'(r_prep[ST_P3].r) * 23'(FRAC_STEP);
        dnum       = 11'(r_prep[ST_P3].r) * FRAC_STEP_REM + FRAC_ROUND;
        fine       = 21'(dnum) * 21'(RECIP_45_FINE);
        n_prep4    = r_prep[ST_P3];
        n_prep4.lo = coarse + 23'(fine[20:16]);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_P1]) r_prep[ST_P1] <= n_prep1;
        if (en[ST_P2]) r_prep[ST_P2] <= n_prep2;
        if (en[ST_P3]) r_prep[ST_P3] <= n_prep3;
        if (en[ST_P4]) r_prep[ST_P4] <= n_prep4;
    end

    // ------------------------------------------------------------------
    // Stage P5: load the CORDIC start vector
    //   polar in:  rotate (x0, 0) by 90 deg - bearing, folded into +-90 deg
    //   rect in:   left half plane mirrored through the origin, angle starts at 180 deg
    // ------------------------------------------------------------------
    logic signed [VEC_W-1:0] r_cx [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] r_cy [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] r_cz [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] n_lx, n_ly;
    logic signed [ANG_W-1:0] n_lz;

    always_comb begin
        logic [31:0]             bin_b;
        logic [31:0]             tu;
        logic signed [ANG_W-1:0] t;
        logic signed [VEC_W-1:0] x0;
        logic signed [31:0]      xs32, ys32;
        logic signed [VEC_W-1:0] xe, ye;
        logic                    fold;
        bin_b = {r_prep[ST_P4].q, r_prep[ST_P4].lo};
        tu    = QUARTER_BIN - bin_b;
        t     = {tu[31], tu};
        x0    = {3'b000, r_prep[ST_P4].x0};
        fold  = (t > Z_QUARTER) || (t < -Z_QUARTER);
        xs32  = {r_meta[ST_P4].ex, 16'h0000};
        ys32  = {r_meta[ST_P4].ey, 16'h0000};
        xe    = {{(VEC_W-32){xs32[31]}}, xs32};
        ye    = {{(VEC_W-32){ys32[31]}}, ys32};
        if (r_meta[ST_P4].mode == REQ_TO_RECT) begin
            n_ly = '0;
            if (fold) begin
                n_lx = -x0;
                n_lz = (t > 0) ? t - Z_HALF : t + Z_HALF;
            end else begin
                n_lx = x0;
                n_lz = t;
            end
        end else begin
            if (r_meta[ST_P4].ex < 0) begin
                n_lx = -xe;
                n_ly = -ye;
                n_lz = Z_HALF;
            end else begin
                n_lx = xe;
                n_ly = ye;
                n_lz = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_P5]) begin
            r_cx[0] <= n_lx;
            r_cy[0] <= n_ly;
            r_cz[0] <= n_lz;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC steps, one register stage each. Vectoring drives y to zero,
    // rotation drives the residual angle to zero; both share one datapath:
    // "cw" adds the shifted y to x and the table angle to z.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_step
        logic                    cw;
        logic signed [VEC_W-1:0] xs, ys;
        logic signed [ANG_W-1:0] at;

        always_comb begin
            xs = r_cx[gi] >>> gi;
            ys = r_cy[gi] >>> gi;
            at = {1'b0, ATAN_BIN[gi]};
            if (r_meta[ST_C0+gi-1].mode == REQ_TO_RECT) begin
                cw = r_cz[gi][ANG_W-1];
            end else begin
                cw = !r_cy[gi][VEC_W-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[ST_C0+gi]) begin
                if (cw) begin
                    r_cx[gi+1] <= r_cx[gi] + ys;
                    r_cy[gi+1] <= r_cy[gi] - xs;
                    r_cz[gi+1] <= r_cz[gi] + at;
                end else begin
                    r_cx[gi+1] <= r_cx[gi] - ys;
                    r_cy[gi+1] <= r_cy[gi] + xs;
                    r_cz[gi+1] <= r_cz[gi] - at;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E1: bearing scale to 1/64 deg, gain removal, component rounding
    // ------------------------------------------------------------------
    logic [46:0]        r_bprod;
    logic [63:0]        r_mprod;
    logic signed [18:0] r_rx, r_ry;

    always_ff @(posedge i_clk) begin
        logic [31:0]             bear_bin;
        logic [VEC_W-2:0]        xpos;
        logic signed [VEC_W-1:0] xr, yr;
        bear_bin = QUARTER_BIN - r_cz[CORDIC_STEPS][31:0];
        xpos     = r_cx[CORDIC_STEPS][VEC_W-1] ? '0 : r_cx[CORDIC_STEPS][VEC_W-2:0];
        xr       = r_cx[CORDIC_STEPS] + VEC_W'(32768);
        yr       = r_cy[CORDIC_STEPS] + VEC_W'(32768);
        if (en[ST_E1]) begin
            r_bprod <= 47'(bear_bin) * 47'(TURN_64THS);
            r_mprod <= 64'(xpos) * 64'(INV_GAIN_Q30);
            r_rx    <= xr[VEC_W-1:16];
            r_ry    <= yr[VEC_W-1:16];
        end
    end

    // ------------------------------------------------------------------
    // Stage E2: round, saturate, select per request, output register
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0] r_out;
    logic [OUT_DATA_W-1:0] n_out;

    always_comb begin
        logic [47:0]        bsum;
        logic [15:0]        bear;
        logic [63:0]        msum;
        logic [17:0]        msh;
        logic [14:0]        o_ang;
        logic [15:0]        o_mag;
        logic signed [16:0] o_x, o_y;
        t_meta              mt;
        mt   = r_meta[ST_E1];
        bsum = 48'(r_bprod) + 48'h0000_8000_0000;
        bear = bsum[47:32];
        msum = r_mprod + 64'h0000_2000_0000_0000;
        msh  = msum[63:46];
        if (mt.mode == REQ_TO_RECT) begin
            o_ang = mt.ang;
            o_mag = mt.mag;
            if (r_rx > COMP_MAX)       o_x = 17'(COMP_MAX);
            else if (r_rx < -COMP_MAX) o_x = 17'(-COMP_MAX);
            else                       o_x = r_rx[16:0];
            if (r_ry > COMP_MAX)       o_y = 17'(COMP_MAX);
            else if (r_ry < -COMP_MAX) o_y = 17'(-COMP_MAX);
            else                       o_y = r_ry[16:0];
        end else begin
            o_x = {mt.ex[15], mt.ex};
            o_y = {mt.ey[15], mt.ey};
            if (mt.ex == 16'sd0 && mt.ey == 16'sd0) begin
                // zero vector: bearing pinned to 90 deg
                o_ang = BEARING_90;
                o_mag = '0;
            end else begin
                // a bearing that rounds up to a full turn wraps to zero
                o_ang = (bear >= 16'(TURN_64THS)) ? '0 : bear[14:0];
                o_mag = (msh > 18'(MAG_LIMIT)) ? MAG_LIMIT : msh[15:0];
            end
        end
        n_out = {7'b0000000, o_y, o_x, o_mag, o_ang};
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_E2]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tdata = r_out;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import bpcc_pkg::*;

    // input transaction as the sender sees it
    typedef struct packed {
        t_req               mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        ang;
        logic [15:0]        mag;
    } t_conv_req;

    // one result transaction, unpacked from m_axis_tdata
    typedef struct packed {
        logic [14:0]        ang;
        logic [15:0]        mag;
        logic signed [16:0] x;
        logic signed [16:0] y;
    } t_conv_res;

    // directed row: known = 1 means want holds the expected result,
    // otherwise the result comes from the predictor
    typedef struct packed {
        t_conv_req req;
        logic      known;
        t_conv_res want;
    } t_dir_row;

    localparam int LATENCY        = CORDIC_STEPS + 8;
    localparam int ATAN_DEPTH     = 24;
    localparam int N_DIRECTED     = 24;
    localparam int RAND_PER_PHASE = 442;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;

    localparam longint BIN_QUARTER = 64'sd1073741824;
    localparam longint BIN_HALF    = 64'sd2147483648;
    localparam longint COMP_LIMIT  = 64'sd46341;

    // arctangent of 2^-i, full circle = 2^32
    localparam logic [31:0] ARCTAN_STEP [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Directed rows: extremes of every field in both modes, zero vector, bearing
    // and magnitude beyond range. Only trivially known results are typed in.
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // zero vector -> bearing 90 deg, magnitude 0, echo
        '{'{REQ_TO_POLAR, 16'h0000, 16'h0000, 15'd0, 16'd0}, 1'b1,
          '{BEARING_90, 16'd0, 17'd0, 17'd0}},
        // zero vector, unused fields all ones
        '{'{REQ_TO_POLAR, 16'h0000, 16'h0000, 15'h7FFF, 16'hFFFF}, 1'b1,
          '{BEARING_90, 16'd0, 17'd0, 17'd0}},
        '{'{REQ_TO_POLAR, 16'h7FFF, 16'h0000, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h8000, 16'h0000, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h0000, 16'h7FFF, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h0000, 16'h8000, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h7FFF, 16'h7FFF, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h8000, 16'h8000, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h8000, 16'h7FFF, 15'h7FFF, 16'hFFFF}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h7FFF, 16'h8000, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h0001, 16'h0000, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'hFFFF, 16'h0000, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'h0000, 16'hFFFF, 15'd0, 16'd0}, 1'b0, '0},
        '{'{REQ_TO_POLAR, 16'hFFFF, 16'hFFFF, 15'd0, 16'd0}, 1'b0, '0},
        // zero magnitude -> zero components, bearing echoed
        '{'{REQ_TO_RECT, 16'h0000, 16'h0000, 15'd0, 16'd0}, 1'b1,
          '{15'd0, 16'd0, 17'd0, 17'd0}},
        // bearing beyond one turn is reduced mod 23040 before the echo
        '{'{REQ_TO_RECT, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'd0}, 1'b1,
          '{15'd9727, 16'd0, 17'd0, 17'd0}},
        '{'{REQ_TO_RECT, 16'h0000, 16'h0000, 15'd0, 16'd46341}, 1'b0, '0},
        '{'{REQ_TO_RECT, 16'h0000, 16'h0000, 15'd5760, 16'd46341}, 1'b0, '0},
        '{'{REQ_TO_RECT, 16'h0000, 16'h0000, 15'd11520, 16'd46341}, 1'b0, '0},
        '{'{REQ_TO_RECT, 16'h0000, 16'h0000, 15'd17280, 16'd46341}, 1'b0, '0},
        // magnitude above the limit saturates
        '{'{REQ_TO_RECT, 16'h0000, 16'h0000, 15'd23039, 16'hFFFF}, 1'b0, '0},
        '{'{REQ_TO_RECT, 16'hFFFF, 16'hFFFF, 15'd23040, 16'd46342}, 1'b0, '0},
        '{'{REQ_TO_RECT, 16'h0000, 16'h0000, 15'h7FFF, 16'd1}, 1'b0, '0},
        '{'{REQ_TO_RECT, 16'h1234, 16'h8765, 15'd2880, 16'd10000}, 1'b0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = REQ_TO_POLAR;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_conv_res pending_results [$];
    int        mismatch_cnt = 0;
    int        cycle_cnt    = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    t_conv_res got_res;
    t_conv_res want_res;

    bearing_polar_cartesian_convert u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Fixed-point CORDIC conversion, bit exact.
    // Polar: 16.16 components, binary angle (2^32 per turn), vectoring toward +x.
    // Rect: gain-compensated start vector, rotate by 90 deg minus the bearing.
    function automatic t_conv_res cordic_convert(input t_conv_req r);
        longint      lx, ly, cx, cy, dx, dy, turn;
        logic [31:0] phi, bin;
        logic [63:0] acc;
        int          ang_red, mag_sat, i;
        t_conv_res   res;
        lx = longint'(r.x);
        ly = longint'(r.y);
        if (r.mode == REQ_TO_POLAR) begin
            res.x = lx[16:0];
            res.y = ly[16:0];
            if (lx == 0 && ly == 0) begin
                res.ang = BEARING_90;
                res.mag = '0;
            end else begin
                cx  = lx * 65536;
                cy  = ly * 65536;
                phi = '0;
                // left half plane: rotate by 180 deg first
                if (cx < 0) begin
                    cx  = -cx;
                    cy  = -cy;
                    phi = 32'h8000_0000;
                end
                for (i = 0; i < CORDIC_STEPS && i < ATAN_DEPTH; i++) begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cy >= 0) begin
                        cx  = cx + dx;
                        cy  = cy - dy;
                        phi = phi + ARCTAN_STEP[i];
                    end else begin
                        cx  = cx - dx;
                        cy  = cy + dy;
                        phi = phi - ARCTAN_STEP[i];
                    end
                end
                // compass bearing = 90 deg - phi, scaled to 1/64 deg
                bin = 32'h4000_0000 - phi;
                acc = ({32'd0, bin} * 64'd23040 + 64'h8000_0000) >> 32;
                if (acc >= 64'd23040) begin
                    acc = '0;
                end
                res.ang = acc[14:0];
                if (cx < 0) begin
                    cx = 0;
                end
                acc = cx;
                acc = (acc * 64'd652032874 + (64'd1 << 45)) >> 46;
                res.mag = (acc > 64'd46341) ? MAG_LIMIT : acc[15:0];
            end
        end else begin
            ang_red = int'(r.ang) % 23040;
            mag_sat = (r.mag > MAG_LIMIT) ? int'(MAG_LIMIT) : int'(r.mag);
            acc  = ((64'(ang_red) << 32) + 64'd11520) / 64'd23040;
            bin  = 32'h4000_0000 - acc[31:0];
            turn = longint'($signed(bin));
            acc  = (64'(mag_sat) * 64'd652032874 + 64'd8192) >> 14;
            cx   = longint'(acc);
            cy   = 0;
            // rotation beyond +-90 deg: flip the start vector
            if (turn > BIN_QUARTER || turn < -BIN_QUARTER) begin
                cx   = -cx;
                turn = (turn > 0) ? turn - BIN_HALF : turn + BIN_HALF;
            end
            for (i = 0; i < CORDIC_STEPS && i < ATAN_DEPTH; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (turn >= 0) begin
                    cx   = cx - dx;
                    cy   = cy + dy;
                    turn = turn - longint'(ARCTAN_STEP[i]);
                end else begin
                    cx   = cx + dx;
                    cy   = cy - dy;
                    turn = turn + longint'(ARCTAN_STEP[i]);
                end
            end
            cx = (cx + 32768) >>> 16;
            cy = (cy + 32768) >>> 16;
            cx = (cx > COMP_LIMIT) ? COMP_LIMIT : ((cx < -COMP_LIMIT) ? -COMP_LIMIT : cx);
            cy = (cy > COMP_LIMIT) ? COMP_LIMIT : ((cy < -COMP_LIMIT) ? -COMP_LIMIT : cy);
            res.ang = 15'(ang_red);
            res.mag = 16'(mag_sat);
            res.x   = cx[16:0];
            res.y   = cy[16:0];
        end
        return res;
    endfunction

    // Offer one input transaction after a random idle gap; the expectation is
    // queued once the transaction is accepted.
    task automatic send_conversion(input t_conv_req r, input logic known,
                                   input t_conv_res want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.mag, r.ang, r.y, r.x};
        s_axis_tuser  <= r.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(known ? want : cordic_convert(r));
    endtask

    // Receiver backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Result checker: each accepted transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.ang = m_axis_tdata[14:0];
            got_res.mag = m_axis_tdata[30:15];
            got_res.x   = m_axis_tdata[47:31];
            got_res.y   = m_axis_tdata[64:48];
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected result: ang %0d mag %0d x %0d y %0d",
                             got_res.ang, got_res.mag,
                             $signed(got_res.x), $signed(got_res.y));
                end
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.ang !== want_res.ang || got_res.mag !== want_res.mag ||
                    got_res.x !== want_res.x || got_res.y !== want_res.y) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("mismatch: exp ang %0d mag %0d x %0d y %0d",
                                 want_res.ang, want_res.mag,
                                 $signed(want_res.x), $signed(want_res.y));
                        $display("          got ang %0d mag %0d x %0d y %0d",
                                 got_res.ang, got_res.mag,
                                 $signed(got_res.x), $signed(got_res.y));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus: three phases of idling (sender light / receiver heavy, the
    // reverse, then none). Directed table first, then random transactions.
    // Between phases the sender holds off until every result has drained.
    initial begin
        t_conv_req req;
        int        phase, n, sel;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 19 : ((phase == 1) ? 67 : 0);
            snk_idle_pct = (phase == 0) ? 67 : ((phase == 1) ? 19 : 0);
            if (phase == 0) begin
                for (n = 0; n < N_DIRECTED; n++) begin
                    send_conversion(DIRECTED[n].req, DIRECTED[n].known, DIRECTED[n].want);
                end
            end
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                sel      = $urandom_range(15);
                req.mode = $urandom_range(1) ? REQ_TO_RECT : REQ_TO_POLAR;
                req.x    = 16'($urandom);
                req.y    = 16'($urandom);
                req.ang  = 15'($urandom);
                req.mag  = 16'($urandom);
                if (req.mode == REQ_TO_POLAR) begin
                    // some zero vectors and some near the origin
                    if (sel == 0) begin
                        req.x = '0;
                        req.y = '0;
                    end else if (sel < 4) begin
                        req.x = 16'($urandom_range(32) - 16);
                        req.y = 16'($urandom_range(32) - 16);
                    end
                end else begin
                    // mostly in-range bearing and magnitude, the rest beyond
                    if (sel < 13) begin
                        req.ang = 15'($urandom_range(23039));
                    end
                    if (sel > 2) begin
                        req.mag = 16'($urandom_range(46341));
                    end
                end
                send_conversion(req, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (pending_results.size() != 0);
        end
        // let any stray transaction surface
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
